@@ sv/iolsh_pkg.sv @@
// ----------------------------------------------------------------------------
// iolsh_pkg
// Shared constants, types and helpers of the I/O latency statistics core.
// ----------------------------------------------------------------------------
package iolsh_pkg;

  localparam int unsigned ClassCount  = 5;
  localparam int unsigned BinCount    = 32;
  localparam int unsigned ScalarWords = 6;
  localparam int unsigned NsPerUs     = 1000;

  localparam int unsigned ClassW     = 3;
  localparam int unsigned BytesW     = 32;
  localparam int unsigned WordW      = 64;
  localparam int unsigned IndexW     = 7;
  localparam int unsigned BinW       = $clog2(BinCount);
  localparam int unsigned BinEntries = ClassCount * BinCount;
  localparam int unsigned BinAddrW   = $clog2(BinEntries);
  localparam int unsigned ScalarIdxW = $clog2(ScalarWords);
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgClassMask  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgBytesEn    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCountEn    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLatencyEn  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgErrorEn    = 3'd4;

  // Operation codes.
  localparam logic OpRecord = 1'b0;
  localparam logic OpRead   = 1'b1;

  // Word positions inside one per-class row of scalar counters.
  localparam logic [ScalarIdxW-1:0] WordBytes   = 3'd0;
  localparam logic [ScalarIdxW-1:0] WordOps     = 3'd1;
  localparam logic [ScalarIdxW-1:0] WordErrors  = 3'd2;
  localparam logic [ScalarIdxW-1:0] WordQueue   = 3'd3;
  localparam logic [ScalarIdxW-1:0] WordService = 3'd4;
  localparam logic [ScalarIdxW-1:0] WordTotal   = 3'd5;

  typedef logic [ScalarWords-1:0][WordW-1:0] row_t;

  typedef enum logic [1:0] {
    RdScalar,
    RdSvcBin,
    RdTotBin,
    RdZero
  } rd_kind_e;

  typedef struct packed {
    logic                  is_read;
    logic                  live;
    logic [ClassW-1:0]     cls;
    logic [BytesW-1:0]     bytes;
    logic                  err;
    logic                  done;
    logic [WordW-1:0]      q_lat;
    logic [WordW-1:0]      s_lat;
    logic [WordW-1:0]      t_lat;
    rd_kind_e              kind;
    logic [ScalarIdxW-1:0] word;
    logic [BinW-1:0]       svc_bin;
    logic [BinW-1:0]       tot_bin;
  } item_t;

  // Lowest latency in ns whose microsecond count reaches 2**k.
  function automatic logic [WordW-1:0] us_threshold(input int unsigned k);
    logic [WordW-1:0] base;
    base = WordW'(NsPerUs);
    return base << k;
  endfunction

endpackage

@@ sv/iolsh_bin_index.sv @@
// ----------------------------------------------------------------------------
// iolsh_bin_index
// Maps a latency in ns to its log2-of-microseconds histogram bin.
// ----------------------------------------------------------------------------
module iolsh_bin_index import iolsh_pkg::*; (
  input  logic [WordW-1:0] ns_i,
  output logic [BinW-1:0]  bin_o
);

  // The thresholds rise with k, so the last one passed gives the bin; the
  // top threshold also provides the cap at the last bin.
  always_comb begin
    bin_o = '0;
    for (int unsigned k = 1; k < BinCount; k++) begin
      if (ns_i >= us_threshold(k)) begin
        bin_o = BinW'(k);
      end
    end
  end

endmodule

@@ sv/io_latency_stats_histogram_core.sv @@
// ----------------------------------------------------------------------------
// io_latency_stats_histogram_core
// A read beat passes stage 1, stage 2 and the output register before its word
// shows on read_data_o. Throughput: one beat per cycle unless a read beat is
// held by a stalled output; the read-modify-write pipe around the counter
// memories (row memory and two bin memories) sets that figure. Reset: registers
// take reset values; per-entry valid bits zero all counters, no clearing pass.
// ----------------------------------------------------------------------------
module io_latency_stats_histogram_core import iolsh_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Input beats.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [ClassW-1:0]   op_class_i,
  input  logic [BytesW-1:0]   bytes_done_i,
  input  logic                error_flag_i,
  input  logic                request_done_i,
  input  logic [WordW-1:0]    queue_latency_i,
  input  logic [WordW-1:0]    service_latency_i,
  input  logic [WordW-1:0]    total_latency_i,
  input  logic [IndexW-1:0]   read_index_i,
  // Result beats.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [WordW-1:0]    read_data_o
);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; unknown indexes are
  // ignored.
  // --------------------------------------------------------------------------
  logic [ClassCount-1:0] class_mask_q;
  logic                  bytes_en_q;
  logic                  count_en_q;
  logic                  lat_en_q;
  logic                  err_en_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_mask_q <= ClassCount'(3);
      bytes_en_q   <= 1'b1;
      count_en_q   <= 1'b1;
      lat_en_q     <= 1'b1;
      err_en_q     <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgClassMask: class_mask_q <= cfg_data_i[ClassCount-1:0];
        CfgBytesEn:   bytes_en_q   <= cfg_data_i[0];
        CfgCountEn:   count_en_q   <= cfg_data_i[0];
        CfgLatencyEn: lat_en_q     <= cfg_data_i[0];
        CfgErrorEn:   err_en_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control. Stage 1 holds the decoded beat and issues the memory
  // reads; stage 2 holds the read data, merges the last write, and writes the
  // updated counters back. Only a read beat can be held in stage 2, and only
  // while the output register is full and stalled.
  // --------------------------------------------------------------------------
  logic  s1_valid_q;
  item_t s1_q;
  logic  s2_valid_q;
  item_t s2_q;
  logic  out_valid_q;
  logic [WordW-1:0] out_data_q;

  logic out_ready;
  logic s2_go;
  logic s1_go;
  logic in_acc;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s2_go      = !s2_valid_q || !s2_q.is_read || out_ready;
  assign s1_go      = !s1_valid_q || s2_go;
  assign in_stall_o = !s1_go;
  assign in_acc     = in_valid_i && s1_go;

  // --------------------------------------------------------------------------
  // Accept-side decode: histogram bins of both latencies, class filter and
  // the meaning of the read index. An out-of-range class is folded to class
  // zero here; such a beat is either dropped or reads as zero anyway.
  // --------------------------------------------------------------------------
  logic [BinW-1:0]       svc_rec_bin;
  logic [BinW-1:0]       tot_rec_bin;
  logic                  cls_ok;
  logic [ClassCount-1:0] mask_sh;
  logic [IndexW-1:0]     svc_off;
  logic [IndexW-1:0]     tot_off;
  rd_kind_e              rd_kind;
  logic [BinW-1:0]       rd_bin;
  item_t                 in_item;

  iolsh_bin_index u_svc_bin (
    .ns_i  (service_latency_i),
    .bin_o (svc_rec_bin)
  );

  iolsh_bin_index u_tot_bin (
    .ns_i  (total_latency_i),
    .bin_o (tot_rec_bin)
  );

  assign cls_ok  = op_class_i < ClassW'(ClassCount);
  assign mask_sh = class_mask_q >> op_class_i;
  assign svc_off = read_index_i - IndexW'(ScalarWords);
  assign tot_off = read_index_i - IndexW'(ScalarWords + BinCount);

  always_comb begin
    rd_kind = RdZero;
    rd_bin  = '0;
    if (cls_ok) begin
      priority if (read_index_i < IndexW'(ScalarWords)) begin
        rd_kind = RdScalar;
      end else if (read_index_i < IndexW'(ScalarWords + BinCount)) begin
        rd_kind = RdSvcBin;
        rd_bin  = svc_off[BinW-1:0];
      end else if (read_index_i < IndexW'(ScalarWords + 2 * BinCount)) begin
        rd_kind = RdTotBin;
        rd_bin  = tot_off[BinW-1:0];
      end else begin
        rd_kind = RdZero;
      end
    end
  end

  always_comb begin
    in_item.is_read = (operation_i == OpRead);
    in_item.live    = (operation_i == OpRecord) && cls_ok && mask_sh[0];
    in_item.cls     = cls_ok ? op_class_i : '0;
    in_item.bytes   = bytes_done_i;
    in_item.err     = error_flag_i;
    in_item.done    = request_done_i;
    in_item.q_lat   = queue_latency_i;
    in_item.s_lat   = service_latency_i;
    in_item.t_lat   = total_latency_i;
    in_item.kind    = rd_kind;
    in_item.word    = read_index_i[ScalarIdxW-1:0];
    in_item.svc_bin = in_item.is_read ? rd_bin : svc_rec_bin;
    in_item.tot_bin = in_item.is_read ? rd_bin : tot_rec_bin;
  end

  // Stage 1 register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_go) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_item;
    end
  end

  // Histogram addresses: class row times bins per class plus the bin.
  logic [BinAddrW-1:0] s1_svc_addr;
  logic [BinAddrW-1:0] s1_tot_addr;

  assign s1_svc_addr = BinAddrW'(s1_q.cls) * BinAddrW'(BinCount) + BinAddrW'(s1_q.svc_bin);
  assign s1_tot_addr = BinAddrW'(s1_q.cls) * BinAddrW'(BinCount) + BinAddrW'(s1_q.tot_bin);

  // --------------------------------------------------------------------------
  // Counter memories. Each row memory entry holds all six scalar counters of
  // one class; the two bin memories hold one histogram counter per entry.
  // Reads are issued when stage 1 moves into stage 2, and the write-back of
  // stage 2 happens on that same edge.
  // --------------------------------------------------------------------------
  row_t             row_mem [ClassCount];
  logic [WordW-1:0] svc_mem [BinEntries];
  logic [WordW-1:0] tot_mem [BinEntries];

  row_t             row_rd_q;
  logic [WordW-1:0] svc_rd_q;
  logic [WordW-1:0] tot_rd_q;
  logic             row_vld_rd_q;
  logic             svc_vld_rd_q;
  logic             tot_vld_rd_q;
  logic [BinAddrW-1:0] s2_svc_addr_q;
  logic [BinAddrW-1:0] s2_tot_addr_q;

  // Valid bits: an entry that was never written reads as zero.
  logic [ClassCount-1:0] row_vld_q;
  logic [BinEntries-1:0] svc_vld_q;
  logic [BinEntries-1:0] tot_vld_q;

  logic             row_we;
  logic             svc_we;
  logic             tot_we;
  row_t             row_new;
  logic [WordW-1:0] svc_new;
  logic [WordW-1:0] tot_new;

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      row_rd_q      <= row_mem[s1_q.cls];
      svc_rd_q      <= svc_mem[s1_svc_addr];
      tot_rd_q      <= tot_mem[s1_tot_addr];
      row_vld_rd_q  <= row_vld_q[s1_q.cls];
      svc_vld_rd_q  <= svc_vld_q[s1_svc_addr];
      tot_vld_rd_q  <= tot_vld_q[s1_tot_addr];
      s2_q          <= s1_q;
      s2_svc_addr_q <= s1_svc_addr;
      s2_tot_addr_q <= s1_tot_addr;
    end
    if (row_we) begin
      row_mem[s2_q.cls] <= row_new;
    end
    if (svc_we) begin
      svc_mem[s2_svc_addr_q] <= svc_new;
    end
    if (tot_we) begin
      tot_mem[s2_tot_addr_q] <= tot_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      row_vld_q  <= '0;
      svc_vld_q  <= '0;
      tot_vld_q  <= '0;
    end else begin
      if (s2_go) begin
        s2_valid_q <= s1_valid_q;
      end
      if (row_we) begin
        row_vld_q[s2_q.cls] <= 1'b1;
      end
      if (svc_we) begin
        svc_vld_q[s2_svc_addr_q] <= 1'b1;
      end
      if (tot_we) begin
        tot_vld_q[s2_tot_addr_q] <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Forwarding. The beat in stage 2 read the memories on the same edge the
  // previous beat wrote them, so it saw the old contents. The last write of
  // each memory is kept here and replaces the read data on an address match.
  // Writes older than that are already visible in the memory.
  // --------------------------------------------------------------------------
  logic                fwd_row_we_q;
  logic [ClassW-1:0]   fwd_row_cls_q;
  row_t                fwd_row_data_q;
  logic                fwd_svc_we_q;
  logic [BinAddrW-1:0] fwd_svc_addr_q;
  logic [WordW-1:0]    fwd_svc_data_q;
  logic                fwd_tot_we_q;
  logic [BinAddrW-1:0] fwd_tot_addr_q;
  logic [WordW-1:0]    fwd_tot_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_row_we_q <= 1'b0;
      fwd_svc_we_q <= 1'b0;
      fwd_tot_we_q <= 1'b0;
    end else if (s2_go) begin
      fwd_row_we_q <= row_we;
      fwd_svc_we_q <= svc_we;
      fwd_tot_we_q <= tot_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      fwd_row_cls_q  <= s2_q.cls;
      fwd_row_data_q <= row_new;
      fwd_svc_addr_q <= s2_svc_addr_q;
      fwd_svc_data_q <= svc_new;
      fwd_tot_addr_q <= s2_tot_addr_q;
      fwd_tot_data_q <= tot_new;
    end
  end

  row_t             row_cur;
  logic [WordW-1:0] svc_cur;
  logic [WordW-1:0] tot_cur;

  always_comb begin
    if (fwd_row_we_q && (fwd_row_cls_q == s2_q.cls)) begin
      row_cur = fwd_row_data_q;
    end else begin
      row_cur = row_vld_rd_q ? row_rd_q : '0;
    end
    if (fwd_svc_we_q && (fwd_svc_addr_q == s2_svc_addr_q)) begin
      svc_cur = fwd_svc_data_q;
    end else begin
      svc_cur = svc_vld_rd_q ? svc_rd_q : '0;
    end
    if (fwd_tot_we_q && (fwd_tot_addr_q == s2_tot_addr_q)) begin
      tot_cur = fwd_tot_data_q;
    end else begin
      tot_cur = tot_vld_rd_q ? tot_rd_q : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Update. Bytes count on every accepted record of an enabled class, errors on
  // those with the error flag; the operation count, latency sums and histograms
  // only when the request finished. All counters wrap at 64 bits.
  // --------------------------------------------------------------------------
  logic add_bytes;
  logic add_err;
  logic add_op;
  logic add_lat;

  assign add_bytes = bytes_en_q;
  assign add_err   = err_en_q && s2_q.err;
  assign add_op    = count_en_q && s2_q.done;
  assign add_lat   = lat_en_q && s2_q.done;

  always_comb begin
    row_new = row_cur;
    if (add_bytes) begin
      row_new[WordBytes] = row_cur[WordBytes] + WordW'(s2_q.bytes);
    end
    if (add_err) begin
      row_new[WordErrors] = row_cur[WordErrors] + WordW'(1);
    end
    if (add_op) begin
      row_new[WordOps] = row_cur[WordOps] + WordW'(1);
    end
    if (add_lat) begin
      row_new[WordQueue]   = row_cur[WordQueue] + s2_q.q_lat;
      row_new[WordService] = row_cur[WordService] + s2_q.s_lat;
      row_new[WordTotal]   = row_cur[WordTotal] + s2_q.t_lat;
    end
  end

  assign svc_new = svc_cur + WordW'(1);
  assign tot_new = tot_cur + WordW'(1);

  assign row_we = s2_go && s2_valid_q && s2_q.live;
  assign svc_we = row_we && add_lat;
  assign tot_we = row_we && add_lat;

  // --------------------------------------------------------------------------
  // Read result and output register. A read beat loads the register when
  // it is free or being emptied in this cycle.
  // --------------------------------------------------------------------------
  logic [WordW-1:0] rd_val;

  always_comb begin
    unique case (s2_q.kind)
      RdScalar: rd_val = row_cur[s2_q.word];
      RdSvcBin: rd_val = svc_cur;
      RdTotBin: rd_val = tot_cur;
      default:  rd_val = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s2_valid_q && s2_q.is_read;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s2_valid_q && s2_q.is_read) begin
      out_data_q <= rd_val;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_out_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s2_valid_q && s2_q.is_read))
    else $error("result beat raised without a read beat in stage 2");

  a_bin_needs_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (svc_we || tot_we) |-> row_we)
    else $error("histogram written without a row update");

  a_accept_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (!s1_valid_q || s2_go))
    else $error("beat accepted while stage 1 is blocked");

  a_row_valid_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_we |=> row_vld_q[$past(s2_q.cls)] && fwd_row_we_q)
    else $error("row write left no valid bit or forwarding entry");

endmodule
